// ===== rtl/core/assert_macros.svh =====
// Concurrent assertion helpers, clocked on clk and held off during rst.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication.
`define ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define ASSERT_NXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/core/ltf_pkg.sv =====
`default_nettype none

package ltf_pkg;

  localparam int DistW    = 9;
  localparam int TrigW    = 9;
  localparam int CmpW     = (DistW > TrigW) ? DistW : TrigW;
  localparam int DutyW    = 4;
  localparam int BoostW   = 6;
  localparam int AddrW    = 5;
  localparam int DataW    = 32;

  localparam logic [1:0] OpSample = 2'd0;
  localparam logic [1:0] OpTick   = 2'd1;
  localparam logic [1:0] OpToggle = 2'd2;

  localparam logic [1:0] SideLeft  = 2'b01;
  localparam logic [1:0] SideRight = 2'b10;

  localparam logic [2:0] RegCruise     = 3'd0;
  localparam logic [2:0] RegBoost      = 3'd1;
  localparam logic [2:0] RegTrigger    = 3'd2;
  localparam logic [2:0] RegLineBoost  = 3'd3;
  localparam logic [2:0] RegTunnBoost  = 3'd4;

  localparam logic [DutyW-1:0]  CruiseRst     = DutyW'(6);
  localparam logic [DutyW-1:0]  BoostRst      = DutyW'(9);
  localparam logic [TrigW-1:0]  TriggerRst    = TrigW'(20);
  localparam logic [BoostW-1:0] LineBoostRst  = BoostW'(25);
  localparam logic [BoostW-1:0] TunnBoostRst  = BoostW'(30);

  typedef struct packed {
    logic [1:0]       operation;
    logic             right_line;
    logic             left_line;
    logic [DistW-1:0] distance_cm;
  } in_item_t;

  typedef struct packed {
    logic [DutyW-1:0] left_duty;
    logic [DutyW-1:0] right_duty;
    logic             in_tunnel;
    logic             running;
    logic             boosting;
  } out_item_t;

  typedef struct packed {
    logic [DutyW-1:0]  cruise_duty;
    logic [DutyW-1:0]  boost_duty;
    logic [TrigW-1:0]  tunnel_trigger_cm;
    logic [BoostW-1:0] line_boost_ms;
    logic [BoostW-1:0] tunnel_boost_ms;
  } cfg_t;

  typedef struct packed {
    logic              enabled;
    logic              was_running;
    logic              tunnel_mode;
    logic [DistW-1:0]  tunnel_width;
    logic [DutyW-1:0]  left_duty_now;
    logic [DutyW-1:0]  right_duty_now;
    logic [BoostW-1:0] boost_left;
    logic [1:0]        boost_sides;
  } st_t;

endpackage

`default_nettype wire

// ===== rtl/core/ltf_cfg.sv =====
`default_nettype none

module ltf_cfg (
  input  wire logic                      clk,
  input  wire logic                      rst,
  input  wire logic                      psel,
  input  wire logic                      penable,
  input  wire logic                      pwrite,
  input  wire logic [ltf_pkg::AddrW-1:0] paddr,
  input  wire logic [ltf_pkg::DataW-1:0] pwdata,
  output logic      [ltf_pkg::DataW-1:0] prdata,
  output logic                           pready,
  output ltf_pkg::cfg_t                  cfg
);
  import ltf_pkg::*;

  logic       wr;
  logic [2:0] idx;

  assign pready = 1'b1;
  assign wr     = psel & penable & pwrite;
  assign idx    = paddr[4:2];

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.cruise_duty       <= CruiseRst;
      cfg.boost_duty        <= BoostRst;
      cfg.tunnel_trigger_cm <= TriggerRst;
      cfg.line_boost_ms     <= LineBoostRst;
      cfg.tunnel_boost_ms   <= TunnBoostRst;
    end else if (wr) begin
      unique case (idx)
        RegCruise:    cfg.cruise_duty       <= pwdata[DutyW-1:0];
        RegBoost:     cfg.boost_duty        <= pwdata[DutyW-1:0];
        RegTrigger:   cfg.tunnel_trigger_cm <= pwdata[TrigW-1:0];
        RegLineBoost: cfg.line_boost_ms     <= pwdata[BoostW-1:0];
        RegTunnBoost: cfg.tunnel_boost_ms   <= pwdata[BoostW-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (idx)
      RegCruise:    prdata = DataW'(cfg.cruise_duty);
      RegBoost:     prdata = DataW'(cfg.boost_duty);
      RegTrigger:   prdata = DataW'(cfg.tunnel_trigger_cm);
      RegLineBoost: prdata = DataW'(cfg.line_boost_ms);
      RegTunnBoost: prdata = DataW'(cfg.tunnel_boost_ms);
      default:      prdata = '0;
    endcase
  end

endmodule

`default_nettype wire

// ===== rtl/core/ltf_step.sv =====
`default_nettype none

module ltf_step (
  input  wire ltf_pkg::st_t      cur,
  input  wire ltf_pkg::cfg_t     cfg,
  input  wire ltf_pkg::in_item_t item,
  output ltf_pkg::st_t           nxt,
  output ltf_pkg::out_item_t     res
);
  import ltf_pkg::*;

  function automatic st_t settle(st_t s, cfg_t c);
    st_t r;
    r = s;
    if (r.boost_sides[0]) r.left_duty_now = c.cruise_duty;
    if (r.boost_sides[1]) r.right_duty_now = c.cruise_duty;
    r.boost_sides = '0;
    r.boost_left  = '0;
    return r;
  endfunction

  function automatic st_t start_boost(st_t s, cfg_t c, logic [1:0] sides);
    st_t r;
    r = s;
    r.boost_sides = sides;
    r.boost_left  = r.tunnel_mode ? c.tunnel_boost_ms : c.line_boost_ms;
    if (r.boost_left == '0) r = settle(r, c);
    return r;
  endfunction

  function automatic st_t resume(st_t s, cfg_t c);
    st_t r;
    r = s;
    if (r.right_duty_now == '0 && r.left_duty_now != '0) begin
      r.right_duty_now = c.boost_duty;
      r = start_boost(r, c, SideRight);
    end else if (r.right_duty_now != '0 && r.left_duty_now == '0) begin
      r.left_duty_now = c.boost_duty;
      r = start_boost(r, c, SideLeft);
    end else if (r.tunnel_mode) begin
      r.left_duty_now  = c.cruise_duty;
      r.right_duty_now = c.cruise_duty;
    end else begin
      r.left_duty_now  = c.boost_duty;
      r.right_duty_now = c.boost_duty;
      r = start_boost(r, c, SideLeft | SideRight);
    end
    return r;
  endfunction

  logic [CmpW-1:0] d_x;
  logic [CmpW-1:0] trig_x;
  logic [CmpW-1:0] w_x;
  logic            rl;
  logic            ll;
  logic            d_nz;

  assign rl   = item.right_line;
  assign ll   = item.left_line;
  assign d_nz = (item.distance_cm != '0);
  assign d_x  = CmpW'(item.distance_cm);
  assign trig_x = CmpW'(cfg.tunnel_trigger_cm);

  always_comb begin
    nxt = cur;
    w_x = '0;
    unique case (item.operation)
      OpSample: begin
        if (cur.boost_left == '0) begin
          if (cur.enabled) begin
            nxt.was_running = 1'b1;
            if (!nxt.tunnel_mode) begin
              if (d_nz && d_x <= trig_x) begin
                nxt.tunnel_mode = 1'b1;
              end else if (!rl && nxt.right_duty_now != '0) begin
                nxt.left_duty_now  = cfg.cruise_duty;
                nxt.right_duty_now = '0;
              end else if (!ll && nxt.left_duty_now != '0) begin
                nxt.left_duty_now  = '0;
                nxt.right_duty_now = cfg.cruise_duty;
              end else if (rl && ll &&
                           (nxt.right_duty_now == '0 || nxt.left_duty_now == '0)) begin
                nxt = resume(nxt, cfg);
              end
            end
            if (nxt.tunnel_mode) begin
              if (!rl || !ll) begin
                nxt.tunnel_mode  = 1'b0;
                nxt.tunnel_width = '0;
              end else begin
                if (nxt.tunnel_width == '0) begin
                  nxt.tunnel_width   = item.distance_cm;
                  nxt.left_duty_now  = '0;
                  nxt.right_duty_now = '0;
                end
                w_x = CmpW'(nxt.tunnel_width);
                if (d_nz && d_x < w_x && nxt.left_duty_now != '0) begin
                  nxt.left_duty_now  = '0;
                  nxt.right_duty_now = cfg.cruise_duty;
                end else if (d_x > w_x && d_x <= trig_x && nxt.right_duty_now != '0) begin
                  nxt.left_duty_now  = cfg.cruise_duty;
                  nxt.right_duty_now = '0;
                end else if (d_x == w_x &&
                             (nxt.right_duty_now == '0 || nxt.left_duty_now == '0)) begin
                  nxt = resume(nxt, cfg);
                end
              end
            end
          end else if (cur.was_running) begin
            nxt.was_running    = 1'b0;
            nxt.tunnel_width   = '0;
            nxt.tunnel_mode    = 1'b0;
            nxt.left_duty_now  = '0;
            nxt.right_duty_now = '0;
          end
        end
      end
      OpTick: begin
        if (cur.boost_left != '0) begin
          nxt.boost_left = cur.boost_left - BoostW'(1);
          if (nxt.boost_left == '0) nxt = settle(nxt, cfg);
        end
      end
      OpToggle: nxt.enabled = ~cur.enabled;
      default: ;
    endcase
  end

  assign res.left_duty  = nxt.left_duty_now;
  assign res.right_duty = nxt.right_duty_now;
  assign res.in_tunnel  = nxt.tunnel_mode;
  assign res.running    = nxt.enabled;
  assign res.boosting   = (nxt.boost_left != '0);

endmodule

`default_nettype wire

// ===== rtl/core/line_and_tunnel_follow_controller_core.sv =====
// Channel   Direction  Handshake           Payload
// in        input      in_valid/in_stall   in_data  (operation, lines, distance)
// out       output     out_valid/out_stall out_data (duties, mode flags)
// cfg       input      APB psel/penable    paddr, pwdata, prdata
//
// One beat per cycle sustained while out does not stall; a taken beat is registered
// in the input register, then its result in the result register, with the state
// update done in the single step between them.
// rst is synchronous: state clears to stopped, line mode; registers reload.
// A stall on out holds the result register and backs up into in_stall.
`default_nettype none

module line_and_tunnel_follow_controller_core (
  input  wire logic                      clk,
  input  wire logic                      rst,
  input  wire logic                      in_valid,
  output logic                           in_stall,
  input  wire ltf_pkg::in_item_t         in_data,
  output logic                           out_valid,
  input  wire logic                      out_stall,
  output ltf_pkg::out_item_t             out_data,
  input  wire logic                      psel,
  input  wire logic                      penable,
  input  wire logic                      pwrite,
  input  wire logic [ltf_pkg::AddrW-1:0] paddr,
  input  wire logic [ltf_pkg::DataW-1:0] pwdata,
  output logic      [ltf_pkg::DataW-1:0] prdata,
  output logic                           pready
);
  import ltf_pkg::*;

  `include "assert_macros.svh"

  cfg_t      cfg;
  st_t       st;
  st_t       st_next;
  in_item_t  in_q;
  out_item_t res;
  logic      in_full;
  logic      fire;
  logic      accept;

  ltf_cfg u_cfg (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  ltf_step u_step (
    .cur  (st),
    .cfg  (cfg),
    .item (in_q),
    .nxt  (st_next),
    .res  (res)
  );

  assign fire     = in_full & (~out_valid | ~out_stall);
  assign in_stall = in_full & ~fire;
  assign accept   = in_valid & ~in_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_full   <= 1'b0;
      out_valid <= 1'b0;
      st        <= '0;
    end else begin
      in_full   <= accept | (in_full & ~fire);
      out_valid <= fire | (out_valid & out_stall);
      if (fire) st <= st_next;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) in_q <= in_data;
    if (fire) out_data <= res;
  end

  `ASSERT_IMP(a_boost_sides, 1'b1, (st.boost_left == '0) == (st.boost_sides == '0), "boost count and sides disagree")
  `ASSERT_IMP(a_width_mode, st.tunnel_width != '0, st.tunnel_mode, "tunnel width held outside tunnel mode")
  `ASSERT_NXT(a_toggle, fire && in_q.operation == OpToggle, st.enabled != $past(st.enabled), "toggle did not flip run flag")
  `ASSERT_IMP(a_stall_full, in_stall, in_full, "stall with empty input register")

endmodule

`default_nettype wire

// ===== verif/ltf_drive_checker.sv =====
`timescale 1ns / 1ps

module ltf_drive_checker
  import ltf_pkg::*;
(
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             in_valid,
  input  wire logic             in_stall,
  input  in_item_t              in_data,
  input  wire logic             out_valid,
  input  wire logic             out_stall,
  input  out_item_t             out_data,
  input  wire logic             psel,
  input  wire logic             penable,
  input  wire logic             pwrite,
  input  wire logic             pready,
  input  wire logic [AddrW-1:0] paddr,
  input  wire logic [DataW-1:0] pwdata,
  output int                    errors,
  output int                    pending
);

  logic [DutyW-1:0]  cruise_cfg, boost_cfg;
  logic [TrigW-1:0]  trigger_cfg;
  logic [BoostW-1:0] line_ms_cfg, tunnel_ms_cfg;

  logic              run_en, ran_since_stop, tunnel_on;
  logic [DistW-1:0]  width_cm;
  logic [DutyW-1:0]  left_now, right_now;
  logic [BoostW-1:0] boost_ticks;
  logic [1:0]        boost_sides;

  out_item_t         expected_q[$];
  int                reports;

  function automatic void settle_boost();
    if ((boost_sides & SideLeft) != 2'b00) left_now = cruise_cfg;
    if ((boost_sides & SideRight) != 2'b00) right_now = cruise_cfg;
    boost_sides = 2'b00;
    boost_ticks = '0;
  endfunction

  function automatic void begin_boost(logic [1:0] sides);
    boost_sides = sides;
    boost_ticks = tunnel_on ? tunnel_ms_cfg : line_ms_cfg;
    if (boost_ticks == '0) settle_boost();
  endfunction

  function automatic void resume_drive();
    if (right_now == '0 && left_now != '0) begin
      right_now = boost_cfg;
      begin_boost(SideRight);
    end else if (right_now != '0 && left_now == '0) begin
      left_now = boost_cfg;
      begin_boost(SideLeft);
    end else if (tunnel_on) begin
      left_now  = cruise_cfg;
      right_now = cruise_cfg;
    end else begin
      left_now  = boost_cfg;
      right_now = boost_cfg;
      begin_boost(SideLeft | SideRight);
    end
  endfunction

  function automatic out_item_t predict_drive(in_item_t b);
    out_item_t r;
    logic [TrigW-1:0] d;
    d = TrigW'(b.distance_cm);
    case (b.operation)
      OpSample: begin
        if (boost_ticks == '0) begin
          if (run_en) begin
            ran_since_stop = 1'b1;
            if (!tunnel_on) begin
              if (d != '0 && d <= trigger_cfg) begin
                tunnel_on = 1'b1;
              end else if (!b.right_line && right_now != '0) begin
                left_now  = cruise_cfg;
                right_now = '0;
              end else if (!b.left_line && left_now != '0) begin
                left_now  = '0;
                right_now = cruise_cfg;
              end else if (b.right_line && b.left_line &&
                           (right_now == '0 || left_now == '0)) begin
                resume_drive();
              end
            end
            if (tunnel_on) begin
              if (!b.right_line || !b.left_line) begin
                tunnel_on = 1'b0;
                width_cm  = '0;
              end else begin
                if (width_cm == '0) begin
                  width_cm  = b.distance_cm;
                  left_now  = '0;
                  right_now = '0;
                end
                if (b.distance_cm != '0 && b.distance_cm < width_cm && left_now != '0) begin
                  left_now  = '0;
                  right_now = cruise_cfg;
                end else if (b.distance_cm > width_cm && d <= trigger_cfg &&
                             right_now != '0) begin
                  left_now  = cruise_cfg;
                  right_now = '0;
                end else if (b.distance_cm == width_cm &&
                             (right_now == '0 || left_now == '0)) begin
                  resume_drive();
                end
              end
            end
          end else if (ran_since_stop) begin
            ran_since_stop = 1'b0;
            width_cm       = '0;
            tunnel_on      = 1'b0;
            left_now       = '0;
            right_now      = '0;
          end
        end
      end
      OpTick: begin
        if (boost_ticks != '0) begin
          boost_ticks = boost_ticks - 1'b1;
          if (boost_ticks == '0) settle_boost();
        end
      end
      OpToggle: run_en = ~run_en;
      default: ;
    endcase
    r.left_duty  = left_now;
    r.right_duty = right_now;
    r.in_tunnel  = tunnel_on;
    r.running    = run_en;
    r.boosting   = (boost_ticks != '0);
    return r;
  endfunction

  always @(posedge clk) begin : watch
    out_item_t want;
    if (rst) begin
      cruise_cfg     = CruiseRst;
      boost_cfg      = BoostRst;
      trigger_cfg    = TriggerRst;
      line_ms_cfg    = LineBoostRst;
      tunnel_ms_cfg  = TunnBoostRst;
      run_en         = 1'b0;
      ran_since_stop = 1'b0;
      tunnel_on      = 1'b0;
      width_cm       = '0;
      left_now       = '0;
      right_now      = '0;
      boost_ticks    = '0;
      boost_sides    = 2'b00;
      errors         = 0;
      reports        = 0;
      expected_q.delete();
    end else begin
      if (out_valid && !out_stall) begin
        if (expected_q.size() == 0) begin
          errors++;
          if (reports < 10) begin
            reports++;
            $display("%0t: result beat with none outstanding: L%0d R%0d T%b E%b B%b",
                     $time, out_data.left_duty, out_data.right_duty, out_data.in_tunnel,
                     out_data.running, out_data.boosting);
          end
        end else begin
          want = expected_q.pop_front();
          if (out_data.left_duty !== want.left_duty || out_data.right_duty !== want.right_duty ||
              out_data.in_tunnel !== want.in_tunnel || out_data.running !== want.running ||
              out_data.boosting !== want.boosting) begin
            errors++;
            if (reports < 10) begin
              reports++;
              $display("%0t: mismatch exp L%0d R%0d T%b E%b B%b got L%0d R%0d T%b E%b B%b",
                       $time, want.left_duty, want.right_duty, want.in_tunnel, want.running,
                       want.boosting, out_data.left_duty, out_data.right_duty,
                       out_data.in_tunnel, out_data.running, out_data.boosting);
            end
          end
        end
      end
      if (in_valid && !in_stall) expected_q.push_back(predict_drive(in_data));
      if (psel && penable && pwrite && pready) begin
        case (paddr[AddrW-1:2])
          RegCruise:    cruise_cfg    = pwdata[DutyW-1:0];
          RegBoost:     boost_cfg     = pwdata[DutyW-1:0];
          RegTrigger:   trigger_cfg   = pwdata[TrigW-1:0];
          RegLineBoost: line_ms_cfg   = pwdata[BoostW-1:0];
          RegTunnBoost: tunnel_ms_cfg = pwdata[BoostW-1:0];
          default: ;
        endcase
      end
    end
    pending = expected_q.size();
  end

endmodule

// ===== verif/line_and_tunnel_follow_controller_core_tb.sv =====
`timescale 1ns / 1ps

module line_and_tunnel_follow_controller_core_tb;
  import ltf_pkg::*;

  localparam logic [1:0] OpUnused = 2'd3;
  localparam int HoldCycles = 60;
  localparam int CycleLimit = 200000;
  localparam int PhaseBeats = 325;

  logic             clk = 1'b0;
  logic             rst;
  logic             in_valid, in_stall, out_valid, out_stall;
  in_item_t         in_data;
  out_item_t        out_data;
  logic             psel, penable, pwrite, pready;
  logic [AddrW-1:0] paddr;
  logic [DataW-1:0] pwdata, prdata;

  int               errors, pending;
  int               cycles = 0;
  int               hold_requests = 0;
  int               holds_done = 0;
  bit               calm = 1'b0;
  logic [DistW-1:0] trig_now, prev_dist;

  line_and_tunnel_follow_controller_core DUT (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .psel      (psel),
    .penable   (penable),
    .pwrite    (pwrite),
    .paddr     (paddr),
    .pwdata    (pwdata),
    .prdata    (prdata),
    .pready    (pready)
  );

  ltf_drive_checker drive_chk (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .psel      (psel),
    .penable   (penable),
    .pwrite    (pwrite),
    .pready    (pready),
    .paddr     (paddr),
    .pwdata    (pwdata),
    .errors    (errors),
    .pending   (pending)
  );

  always #2 clk = ~clk;

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CycleLimit) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  // result side: random stalls, plus long hold-offs on request
  initial begin
    out_stall = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_requests != holds_done) begin
        out_stall <= 1'b1;
        repeat (HoldCycles - 1) @(negedge clk);
        holds_done++;
      end else begin
        out_stall <= !calm && ($urandom_range(99) < 29);
      end
    end
  end

  task automatic send_item(input logic [1:0] op, input logic rl, input logic ll,
                           input logic [DistW-1:0] d);
    while (!calm && $urandom_range(99) < 29) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= in_item_t'{op, rl, ll, d};
    @(posedge clk);
    while (in_stall) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (pending != 0) @(negedge clk);
  endtask

  task automatic apb_write(input logic [2:0] idx, input logic [DataW-1:0] val);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= AddrW'({idx, 2'b00});
    pwdata  <= val;
    @(negedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic load_config(input int cr, input int bo, input int tr, input int lb,
                             input int tb);
    drain();
    repeat (4) @(negedge clk);
    apb_write(RegCruise, DataW'(cr));
    apb_write(RegBoost, DataW'(bo));
    apb_write(RegTrigger, DataW'(tr));
    apb_write(RegLineBoost, DataW'(lb));
    apb_write(RegTunnBoost, DataW'(tb));
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    trig_now = DistW'(tr);
  endtask

  initial begin
    int               r, lim;
    logic [1:0]       op;
    logic             rl, ll;
    logic [DistW-1:0] d;

    rst       = 1'b1;
    in_valid  = 1'b0;
    in_data   = '0;
    psel      = 1'b0;
    penable   = 1'b0;
    pwrite    = 1'b0;
    paddr     = '0;
    pwdata    = '0;
    trig_now  = TriggerRst;
    prev_dist = '0;
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // cruise duty ten, boost duty above ten, short line boost, zero tunnel boost
    load_config(10, 15, 20, 2, 0);
    send_item(OpSample, 1'b1, 1'b1, '0);
    send_item(OpUnused, 1'b0, 1'b0, '1);
    send_item(OpTick, 1'b1, 1'b1, 5);
    send_item(OpToggle, 1'b1, 1'b1, '0);
    send_item(OpSample, 1'b1, 1'b1, '0);
    send_item(OpSample, 1'b0, 1'b0, 3);
    send_item(OpToggle, 1'b0, 1'b1, 7);
    send_item(OpToggle, 1'b1, 1'b0, 8);
    send_item(OpTick, 1'b0, 1'b0, '1);
    send_item(OpTick, 1'b1, 1'b1, '0);
    send_item(OpSample, 1'b0, 1'b1, '1);
    send_item(OpSample, 1'b1, 1'b1, 300);
    send_item(OpTick, 1'b1, 1'b1, 0);
    send_item(OpTick, 1'b1, 1'b1, 0);
    send_item(OpSample, 1'b1, 1'b0, 21);
    send_item(OpSample, 1'b1, 1'b1, 20);
    send_item(OpSample, 1'b1, 1'b1, 15);
    send_item(OpSample, 1'b1, 1'b1, 20);
    send_item(OpSample, 1'b0, 1'b1, 20);
    send_item(OpSample, 1'b1, 1'b1, 1);
    send_item(OpToggle, 1'b1, 1'b1, 0);
    send_item(OpSample, 1'b1, 1'b1, 9);
    send_item(OpSample, 1'b1, 1'b1, 9);

    for (int p = 0; p < 6; p++) begin
      case (p)
        0: load_config(CruiseRst, BoostRst, TriggerRst, LineBoostRst, TunnBoostRst);
        1: load_config(0, 0, 0, 0, 0);
        2: load_config(15, 15, 511, 63, 63);
        default: load_config($urandom_range(10), $urandom_range(15), $urandom_range(511),
                             $urandom_range(6), $urandom_range(6));
      endcase
      for (int n = 0; n < PhaseBeats; n++) begin
        if (p == 0 && n == 100) hold_requests++;
        if (p == 1 && n == 150) drain();
        calm = (p == 2 && n < 150);
        r = $urandom_range(99);
        if (r < 50) op = OpSample;
        else if (r < 88) op = OpTick;
        else if (r < 96) op = OpToggle;
        else op = OpUnused;
        r = $urandom_range(99);
        if (r < 65) begin
          rl = 1'b1;
          ll = 1'b1;
        end else begin
          rl = 1'($urandom_range(1));
          ll = 1'($urandom_range(1));
        end
        r = $urandom_range(99);
        lim = (int'(trig_now) + 4 > 511) ? 511 : int'(trig_now) + 4;
        if (r < 8) d = '0;
        else if (r < 35) d = prev_dist;
        else if (r < 70) d = DistW'($urandom_range(lim));
        else d = DistW'($urandom_range(511));
        if (op == OpSample) prev_dist = d;
        send_item(op, rl, ll, d);
      end
    end

    drain();
    repeat (10) @(negedge clk);
    if (errors == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
+incdir+rtl/core
rtl/core/ltf_pkg.sv
rtl/core/ltf_cfg.sv
rtl/core/ltf_step.sv
rtl/core/line_and_tunnel_follow_controller_core.sv
verif/ltf_drive_checker.sv
verif/line_and_tunnel_follow_controller_core_tb.sv
